// ----- rtl/core/gfd_pkg.sv -----
// ----------------------------------------------------------------------------
// gfd_pkg: shared types and constants for the gauge reply frame decoder
// Character codes, frame offsets, result struct and address digit helper.
// ----------------------------------------------------------------------------
package gfd_pkg;

	localparam int unsigned POS_W    = 7;
	localparam int unsigned MANT_W   = 24;
	localparam int unsigned EXP_W    = 8;
	localparam int unsigned EACC_W   = 7;
	localparam int unsigned FRAC_W   = 3;
	localparam int unsigned PADDR_W  = 2;
	localparam int unsigned PDATA_W  = 32;

	localparam int unsigned BUFFER_BYTES_DEF = 64;

	localparam logic [7:0] ADDR_RESET = 8'd253;

	// register map
	localparam logic [PADDR_W-1:0] REG_DEVICE_ADDRESS = 2'd0;

	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'd48;

	localparam logic [POS_W-1:0] ADDR_LAST   = 7'd3;
	localparam logic [POS_W-1:0] VALUE_FIRST = 7'd7;
	localparam logic [POS_W-1:0] VALUE_LAST  = 7'd13;

	localparam logic [FRAC_W-1:0] FRAC_MAX = 3'd7;
	localparam logic [EACC_W-1:0] EACC_MAX = 7'd127;

	typedef enum logic [1:0] {
		PH_INT  = 2'd0,
		PH_FRAC = 2'd1,
		PH_SIGN = 2'd2,
		PH_EXP  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [MANT_W-1:0]        mantissa;
		logic signed [EXP_W-1:0]  exponent;
		logic                     format_ok;
	} result_t;

	// Expected frame byte at header offset sel: '@', then the address digits.
	function automatic logic [7:0] addr_char(input logic [7:0] a, input logic [1:0] sel);
		logic [1:0]  h;
		logic [7:0]  base;
		logic [6:0]  r;
		logic [14:0] prod;
		logic [3:0]  t;
		logic [6:0]  tx10;
		logic [3:0]  u;
		logic [7:0]  c;
		if (a >= 8'd200) begin
			h    = 2'd2;
			base = 8'd200;
		end else if (a >= 8'd100) begin
			h    = 2'd1;
			base = 8'd100;
		end else begin
			h    = 2'd0;
			base = 8'd0;
		end
		r    = 7'(a - base);
		// r / 10 for r < 100 by reciprocal multiply
		prod = 15'(r) * 15'd205;
		t    = prod[14:11];
		tx10 = 7'(t) * 7'd10;
		u    = 4'(r - tx10);
		case (sel)
			2'd0:    c = CH_AT;
			2'd1:    c = CH_ZERO + 8'(h);
			2'd2:    c = CH_ZERO + 8'(t);
			default: c = CH_ZERO + 8'(u);
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/gfd_frame.sv -----
// ----------------------------------------------------------------------------
// gfd_frame: frame tracking and value parse state
// Header match, value character decode, end-of-frame detect and result build.
// ----------------------------------------------------------------------------
module gfd_frame #(
	parameter int unsigned BUFFER_BYTES = gfd_pkg::BUFFER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          byte_s1,
	input  logic [7:0]          device_address,
	output logic                emit,
	output gfd_pkg::result_t    res
);

	logic [gfd_pkg::POS_W-1:0]  pos_q,  pos_n;
	logic [7:0]                 prev_q, prev_n;
	gfd_pkg::phase_t            phase_q, phase_n;
	logic [gfd_pkg::MANT_W-1:0] mant_q, mant_n;
	logic [gfd_pkg::FRAC_W-1:0] frac_q, frac_n;
	logic [gfd_pkg::EACC_W-1:0] exp_q,  exp_n;
	logic                       neg_q,  neg_n;
	logic                       err_q,  err_n;

	// parsed values after this byte
	gfd_pkg::phase_t            p_phase;
	logic [gfd_pkg::MANT_W-1:0] p_mant;
	logic [gfd_pkg::FRAC_W-1:0] p_frac;
	logic [gfd_pkg::EACC_W-1:0] p_exp;
	logic                       p_neg;
	logic                       p_err;

	logic                       is_dig;
	logic [3:0]                 dig;
	logic [gfd_pkg::MANT_W-1:0] mant_x10;
	logic [10:0]                exp_x10;
	logic                       in_value;
	logic                       buf_full;
	logic                       ended;
	logic [7:0]                 expect_b;
	logic signed [8:0]          e_full;
	logic                       ok;

	assign is_dig   = (byte_s1 >= gfd_pkg::CH_ZERO) && (byte_s1 <= gfd_pkg::CH_ZERO + 8'd9);
	assign dig      = is_dig ? 4'(byte_s1 - gfd_pkg::CH_ZERO) : 4'd0;
	assign mant_x10 = (mant_q << 3) + (mant_q << 1) + gfd_pkg::MANT_W'(dig);
	assign exp_x10  = (11'(exp_q) << 3) + (11'(exp_q) << 1) + 11'(dig);
	assign in_value = (pos_q >= gfd_pkg::VALUE_FIRST) && (pos_q <= gfd_pkg::VALUE_LAST);
	assign buf_full = pos_q >= gfd_pkg::POS_W'(BUFFER_BYTES);
	assign ended    = (byte_s1 == gfd_pkg::CH_F) && (prev_q == gfd_pkg::CH_F);
	assign expect_b = gfd_pkg::addr_char(device_address, pos_q[1:0]);

	// value character decode
	always_comb begin
		p_phase = phase_q;
		p_mant  = mant_q;
		p_frac  = frac_q;
		p_exp   = exp_q;
		p_neg   = neg_q;
		p_err   = err_q;
		if (in_value) begin
			unique case (phase_q)
				gfd_pkg::PH_INT: begin
					if (byte_s1 == gfd_pkg::CH_DOT) p_phase = gfd_pkg::PH_FRAC;
					else if (is_dig) p_mant = mant_x10;
					else p_err = 1'b1;
				end
				gfd_pkg::PH_FRAC: begin
					if (byte_s1 == gfd_pkg::CH_E) p_phase = gfd_pkg::PH_SIGN;
					else if (is_dig) begin
						p_mant = mant_x10;
						if (frac_q < gfd_pkg::FRAC_MAX) p_frac = frac_q + 3'd1;
					end else p_err = 1'b1;
				end
				gfd_pkg::PH_SIGN: begin
					if (byte_s1 == gfd_pkg::CH_PLUS) begin
						p_neg   = 1'b0;
						p_phase = gfd_pkg::PH_EXP;
					end else if (byte_s1 == gfd_pkg::CH_MINUS) begin
						p_neg   = 1'b1;
						p_phase = gfd_pkg::PH_EXP;
					end else p_err = 1'b1;
				end
				default: begin
					if (is_dig) begin
						p_exp = (exp_x10 > 11'(gfd_pkg::EACC_MAX)) ? gfd_pkg::EACC_MAX
							: exp_x10[gfd_pkg::EACC_W-1:0];
					end else p_err = 1'b1;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		pos_n   = pos_q;
		prev_n  = prev_q;
		phase_n = phase_q;
		mant_n  = mant_q;
		frac_n  = frac_q;
		exp_n   = exp_q;
		neg_n   = neg_q;
		err_n   = err_q;
		emit    = 1'b0;
		if (buf_full || (pos_q <= gfd_pkg::ADDR_LAST && byte_s1 != expect_b)) begin
			pos_n   = '0;
			prev_n  = '0;
			phase_n = gfd_pkg::PH_INT;
			mant_n  = '0;
			frac_n  = '0;
			exp_n   = '0;
			neg_n   = 1'b0;
			err_n   = 1'b0;
		end else if (pos_q <= gfd_pkg::ADDR_LAST) begin
			pos_n  = pos_q + 7'd1;
			prev_n = byte_s1;
		end else if (ended) begin
			emit    = 1'b1;
			pos_n   = '0;
			prev_n  = '0;
			phase_n = gfd_pkg::PH_INT;
			mant_n  = '0;
			frac_n  = '0;
			exp_n   = '0;
			neg_n   = 1'b0;
			err_n   = 1'b0;
		end else begin
			pos_n   = pos_q + 7'd1;
			prev_n  = byte_s1;
			phase_n = p_phase;
			mant_n  = p_mant;
			frac_n  = p_frac;
			exp_n   = p_exp;
			neg_n   = p_neg;
			err_n   = p_err;
		end
	end

	// result fields
	always_comb begin
		e_full = p_neg ? -$signed({2'b00, p_exp}) : $signed({2'b00, p_exp});
		e_full = e_full - $signed({6'd0, p_frac});
		if (e_full < -9'sd128) e_full = -9'sd128;
		ok = !p_err && (p_phase == gfd_pkg::PH_EXP) && (pos_q >= gfd_pkg::VALUE_LAST);
		res.format_ok = ok;
		res.mantissa  = ok ? p_mant : '0;
		res.exponent  = ok ? e_full[gfd_pkg::EXP_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			prev_q  <= '0;
			phase_q <= gfd_pkg::PH_INT;
			mant_q  <= '0;
			frac_q  <= '0;
			exp_q   <= '0;
			neg_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (fire) begin
			pos_q   <= pos_n;
			prev_q  <= prev_n;
			phase_q <= phase_n;
			mant_q  <= mant_n;
			frac_q  <= frac_n;
			exp_q   <= exp_n;
			neg_q   <= neg_n;
			err_q   <= err_n;
		end
	end

endmodule

// ----- rtl/core/gfd_out.sv -----
// ----------------------------------------------------------------------------
// gfd_out: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module gfd_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  gfd_pkg::result_t           res,
	output logic                       free,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,
	output logic                       m_tuser
);

	logic             valid_q;
	gfd_pkg::result_t res_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {res_q.exponent, res_q.mantissa};
	assign m_tuser  = res_q.format_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

endmodule

// ----- rtl/core/gauge_reply_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// gauge_reply_frame_decoder: ASCII gauge reply parser
// Finds addressed reply frames in a byte stream and decodes their value field.
// ----------------------------------------------------------------------------
// One received byte per input transfer; the block takes a byte every cycle
// unless stalled. Each byte is held in the input register, where the frame
// state (offset, last byte, parse phase and accumulators) is updated by a
// single pass of logic, and a frame end loads the result register. Throughput
// is one byte per cycle; the input stalls only when a frame end meets a full
// result register that is not being drained. A frame is '@', the device
// address as three decimal digits, then free bytes; offsets 7..13 carry the
// value (digits '.' digits 'E' sign digits) and two 'F' bytes in a row end
// the frame. A header mismatch drops the byte and restarts the hunt; a frame
// longer than BUFFER_BYTES is thrown away without a result. The address
// register sits at APB offset 0 and resets to 253; write it only while no
// byte is in flight.
module gauge_reply_frame_decoder #(
	parameter int unsigned BUFFER_BYTES = gfd_pkg::BUFFER_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // [23:0] value_mantissa, [31:24] value_exponent
	output logic                          m_tuser,   // [0] format_ok
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gfd_pkg::PADDR_W-1:0]   paddr,
	input  logic [gfd_pkg::PDATA_W-1:0]   pwdata,
	output logic [gfd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [7:0]       dev_addr_q;
	logic             emit;
	logic             out_free;
	logic             fire;
	gfd_pkg::result_t res;

	// stage advances unless it would produce a result with nowhere to go
	assign fire     = valid_s1 && (!emit || out_free);
	assign s_tready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// APB register file: single register, zero wait states
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr)
			gfd_pkg::REG_DEVICE_ADDRESS: prdata = {24'd0, dev_addr_q};
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= gfd_pkg::ADDR_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr == gfd_pkg::REG_DEVICE_ADDRESS) begin
			dev_addr_q <= pwdata[7:0];
		end
	end

	gfd_frame #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.byte_s1        (byte_s1),
		.device_address (dev_addr_q),
		.emit           (emit),
		.res            (res)
	);

	gfd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (valid_s1 && emit),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- rtl/core/gfd_checker.sv -----
// ----------------------------------------------------------------------------
// gfd_checker: port-level checks for the gauge reply frame decoder
// Result stream ordering, error encoding and input readiness.
// ----------------------------------------------------------------------------
module gfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// format error results carry zero payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 32'd0)
		else $error("error result with nonzero payload");

	// at most seven digits in the mantissa
	a_mant_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:0] <= 24'd9999999)
		else $error("mantissa out of range");

	// empty result register never blocks input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a new result follows a byte transfer through the input and result registers
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without input transfer");

endmodule

bind gauge_reply_frame_decoder gfd_checker u_gfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- tb/gauge_reply_frame_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// gauge_reply_frame_decoder_tb: self-checking bench for the gauge reply decoder
// Streams addressed ASCII reply frames into the decoder and checks every
// decoded value against a cycle-free model of the frame parser. A directed
// frame table comes first, then random frames under several device addresses.
// ----------------------------------------------------------------------------
module gauge_reply_frame_decoder_tb;
	import gfd_pkg::*;

	localparam int WATCHDOG_LIMIT  = 3000;  // idle cycles before giving up
	localparam int SETTLE_CYCLES   = 4;     // drain margin after the last owed result
	localparam int ITEMS_PER_PHASE = 155;   // frame bytes per address setting
	localparam int N_PHASES        = 6;
	localparam int HOLD_CYCLES     = 400;   // one long receiver back-off
	localparam int HOLD_AFTER      = 30;    // ...starting after this many results
	localparam int N_ROWS          = 16;

	localparam result_t FMT_ERR_RESULT = '{mantissa: '0, exponent: '0, format_ok: 1'b0};

	// How a directed frame is checked: by the decode model, or against the
	// all-zero format error result FMT_ERR_RESULT.
	typedef enum bit {
		CHK_MODEL,
		CHK_FMT_ERR
	} check_t;

	// Receiver stall patterns.
	typedef enum logic [1:0] {
		RX_FREE,
		RX_SPARSE,
		RX_TOGGLE,
		RX_COIN
	} rx_mode_t;

	// Directed frame: lead text, fill bytes, tail text.
	typedef struct {
		string      lead;
		int         fill;
		logic [7:0] fill_byte;
		string      tail;
		check_t     chk;
	} frame_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // [7:0] rx_byte
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;   // [23:0] value_mantissa, [31:24] value_exponent
	logic                 m_tuser;   // [0] format_ok
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	gauge_reply_frame_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Decode model: frame hunt, value parse and result, one byte per call.
	// ------------------------------------------------------------------------
	logic [7:0]        cfg_device_addr;
	logic [POS_W-1:0]  frame_pos;
	logic [7:0]        last_byte;
	phase_t            phase;
	logic [MANT_W-1:0] mant_acc;
	logic [FRAC_W-1:0] frac_cnt;
	logic [EACC_W-1:0] exp_acc;
	logic              exp_neg;
	logic              fmt_err;

	result_t decoded_q[$];  // decoded values still owed by the block
	int      errors;
	int      results_seen;
	int      burst_left;

	function automatic void clear_frame();
		frame_pos = '0;
		last_byte = '0;
		phase     = PH_INT;
		mant_acc  = '0;
		frac_cnt  = '0;
		exp_acc   = '0;
		exp_neg   = 1'b0;
		fmt_err   = 1'b0;
	endfunction

	// '@' then the address as hundreds, tens and units digits
	function automatic logic [7:0] header_char(input logic [7:0] a, input logic [1:0] k);
		case (k)
			2'd0:    return CH_AT;
			2'd1:    return CH_ZERO + 8'(a / 100);
			2'd2:    return CH_ZERO + 8'((a / 10) % 10);
			default: return CH_ZERO + 8'(a % 10);
		endcase
	endfunction

	function automatic void parse_value_byte(input logic [7:0] b);
		bit         dig;
		logic [3:0] d;
		int         ex;
		dig = (b >= CH_ZERO) && (b <= CH_ZERO + 8'd9);
		d   = dig ? 4'(b - CH_ZERO) : 4'd0;
		case (phase)
			PH_INT: begin
				if (b == CH_DOT) phase = PH_FRAC;
				else if (dig) mant_acc = mant_acc * 24'd10 + 24'(d);
				else fmt_err = 1'b1;
			end
			PH_FRAC: begin
				if (b == CH_E) phase = PH_SIGN;
				else if (dig) begin
					mant_acc = mant_acc * 24'd10 + 24'(d);
					if (frac_cnt < FRAC_MAX) frac_cnt = frac_cnt + 3'd1;
				end else fmt_err = 1'b1;
			end
			PH_SIGN: begin
				if (b == CH_PLUS) begin
					exp_neg = 1'b0;
					phase   = PH_EXP;
				end else if (b == CH_MINUS) begin
					exp_neg = 1'b1;
					phase   = PH_EXP;
				end else fmt_err = 1'b1;
			end
			default: begin
				if (dig) begin
					ex      = int'(exp_acc) * 10 + int'(d);
					exp_acc = (ex > int'(EACC_MAX)) ? EACC_MAX : 7'(ex);
				end else fmt_err = 1'b1;
			end
		endcase
	endfunction

	// Returns 1 when the byte closes a frame; r then holds the decoded value.
	function automatic bit decode_byte(input logic [7:0] b, output result_t r);
		logic [POS_W-1:0] pos;
		bit               ended;
		int               e;
		r   = FMT_ERR_RESULT;
		pos = frame_pos;
		if (int'(pos) >= BUFFER_BYTES_DEF) begin
			// frame too long: thrown away silently
			clear_frame();
			return 1'b0;
		end
		if (pos <= ADDR_LAST) begin
			if (b != header_char(cfg_device_addr, pos[1:0])) begin
				clear_frame();
				return 1'b0;
			end
			last_byte = b;
			frame_pos = pos + 7'd1;
			return 1'b0;
		end
		if (pos >= VALUE_FIRST && pos <= VALUE_LAST) parse_value_byte(b);
		ended     = (b == CH_F) && (last_byte == CH_F);
		last_byte = b;
		frame_pos = pos + 7'd1;
		if (!ended) return 1'b0;
		if (!fmt_err && phase == PH_EXP && pos >= VALUE_LAST) begin
			e = int'(exp_acc);
			if (exp_neg) e = -e;
			e = e - int'(frac_cnt);
			if (e < -128) e = -128;
			if (e > 127) e = 127;
			r.mantissa  = mant_acc;
			r.exponent  = 8'(e);
			r.format_ok = 1'b1;
		end
		clear_frame();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Directed frames (device address at its reset value 253).
	// ------------------------------------------------------------------------
	frame_row_t frame_rows [N_ROWS] = '{
		'{"@253abc1.23E+02FF", 0, 8'h00, "", CHK_MODEL},    // digit past offset 13 ignored
		'{"@253", 3, 8'h00, "1.E-127FF", CHK_MODEL},         // zero bytes as free bytes
		'{"@253", 3, 8'hFF, "1.E+999FF", CHK_MODEL},         // all-ones bytes; exp saturates
		'{"@253---.1E-999FF", 0, 8'h00, "", CHK_MODEL},     // exponent clamps at -128
		'{"@253---.9999E+FF", 0, 8'h00, "", CHK_MODEL},     // empty integer and exponent
		'{"@253---9999.E-FF", 0, 8'h00, "", CHK_MODEL},     // empty fraction
		'{"@253---0.00E-0FF", 0, 8'h00, "", CHK_MODEL},     // zero value
		'{"@253---12.3E+4", 0, 8'h00, "xyzFF", CHK_MODEL},  // trailing bytes before end
		'{"@253---1x3.E+0FF", 0, 8'h00, "", CHK_FMT_ERR},   // non-digit in integer part
		'{"@253---1.2E*05FF", 0, 8'h00, "", CHK_FMT_ERR},   // sign missing after E
		'{"@253---1.2FF", 0, 8'h00, "", CHK_FMT_ERR},       // end lands inside value
		'{"@253FF", 0, 8'h00, "", CHK_FMT_ERR},             // end before the value
		'{"@2@253---1.E+0FF", 0, 8'h00, "", CHK_MODEL},     // '@' mismatch not re-hunted
		'{"@254---1.E+0FF", 0, 8'h00, "", CHK_MODEL},       // wrong address, no result
		'{"@253---1.5E-01", 48, CH_MINUS, "FF", CHK_MODEL}, // longest frame that fits
		'{"@253---1.5E-01", 50, CH_MINUS, "FF", CHK_MODEL}  // overflow, discarded
	};

	// ------------------------------------------------------------------------
	// Byte sender: bursts of random length with random gaps. Each accepted
	// transfer runs the model; a closing byte queues its decoded value.
	// ------------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b, input check_t chk);
		int      gap;
		result_t got;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
			                                         : $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (decode_byte(b, got)) begin
			if (chk == CHK_FMT_ERR) decoded_q.push_back(FMT_ERR_RESULT);
			else decoded_q.push_back(got);
		end
	endtask

	task automatic push_text(input string s, input check_t chk);
		for (int k = 0; k < s.len(); k++) push_byte(s[k], chk);
	endtask

	// any byte but 'F', so no accidental frame end
	function automatic logic [7:0] free_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CH_F) b = CH_F + 8'd1;
		return b;
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// One random frame. Most are well formed with random content; the rest
	// carry a broken value, end short, run long, miss the address or are
	// plain line noise. Only bytes of frames that reach the parser are counted.
	task automatic push_random_frame(output int counted);
		logic [7:0] fq[$];
		logic [7:0] val[$];
		int         kind;
		int         ni;
		int         nf;
		int         n;
		kind    = $urandom_range(0, 99);
		counted = 0;
		if (kind >= 94) begin
			n = $urandom_range(1, 10);
			repeat (n) fq.push_back(8'($urandom_range(0, 255)));
		end else begin
			for (int k = 0; k < 4; k++) fq.push_back(header_char(cfg_device_addr, 2'(k)));
			if (kind >= 88) fq[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
			if (kind >= 75 && kind < 83) begin
				n = $urandom_range(0, 9);
				repeat (n) fq.push_back(free_byte());
			end else begin
				repeat (3) fq.push_back(free_byte());
				// seven value characters: digits '.' digits 'E' sign digits
				ni = $urandom_range(0, 4);
				nf = $urandom_range(0, 4 - ni);
				repeat (ni) val.push_back(rand_digit());
				val.push_back(CH_DOT);
				repeat (nf) val.push_back(rand_digit());
				val.push_back(CH_E);
				val.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
				repeat (4 - ni - nf) val.push_back(rand_digit());
				if (kind >= 65 && kind < 75) val[$urandom_range(0, 6)] = 8'($urandom_range(0, 255));
				fq = {fq, val};
				if (kind >= 83 && kind < 88) n = $urandom_range(44, 52);
				else n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
				repeat (n) fq.push_back(free_byte());
			end
			fq.push_back(CH_F);
			fq.push_back(CH_F);
			if (kind < 88) counted = fq.size();
		end
		foreach (fq[i]) push_byte(fq[i], CHK_MODEL);
	endtask

	// Stop sending and let every owed result and in-flight byte drain.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// APB register access
	// ------------------------------------------------------------------------
	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] a,
	                          input logic [PDATA_W-1:0] v, output logic [PDATA_W-1:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_device_address(input logic [7:0] a);
		logic [PDATA_W-1:0] rd;
		apb_access(1'b1, REG_DEVICE_ADDRESS, PDATA_W'(a), rd);
		cfg_device_addr = a;
		apb_access(1'b0, REG_DEVICE_ADDRESS, '0, rd);
		if (rd !== PDATA_W'(a)) begin
			errors++;
			$display("%0t: device_address readback: expected %0d, actual %0d", $time, a, rd);
		end
	endtask

	// ------------------------------------------------------------------------
	// Result checker: each result transfer against the oldest owed value.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (decoded_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual mant=%0d exp=%0d ok=%0b",
				         $time, m_tdata[23:0], $signed(m_tdata[31:24]), m_tuser);
			end else begin
				want = decoded_q.pop_front();
				if (m_tdata[23:0] !== want.mantissa || m_tdata[31:24] !== want.exponent ||
				    m_tuser !== want.format_ok) begin
					errors++;
					$display("%0t: result mismatch: expected mant=%0d exp=%0d ok=%0b",
					         $time, want.mantissa, want.exponent, want.format_ok);
					$display("%0t:                  actual   mant=%0d exp=%0d ok=%0b",
					         $time, m_tdata[23:0], $signed(m_tdata[31:24]), m_tuser);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: its own stall pattern, plus one long hold-off that lets the
	// result register fill and back up the byte input.
	// ------------------------------------------------------------------------
	initial begin
		rx_mode_t rx_mode;
		int       mode_left;
		int       hold_left;
		bit       hold_done;
		m_tready  = 1'b0;
		rx_mode   = RX_FREE;
		mode_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (rx_mode)
					RX_FREE:   m_tready <= 1'b1;
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) != 0);
					RX_TOGGLE: m_tready <= ~m_tready;
					default:   m_tready <= $urandom_range(0, 1);
				endcase
			end
		end
	end

	// Watchdog: too long without any transfer ends the run.
	always @(posedge clk) begin
		int idle_cycles;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			idle_cycles = 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0] addr;
		int         sent;
		int         n;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		errors       = 0;
		results_seen = 0;
		burst_left   = 0;
		cfg_device_addr = ADDR_RESET;
		clear_frame();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames at the reset address
		foreach (frame_rows[i]) begin
			push_text(frame_rows[i].lead, frame_rows[i].chk);
			repeat (frame_rows[i].fill) push_byte(frame_rows[i].fill_byte, frame_rows[i].chk);
			push_text(frame_rows[i].tail, frame_rows[i].chk);
		end

		// random frames, one address setting per phase, extremes first
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0:       addr = 8'd0;
				1:       addr = 8'd255;
				2:       addr = ADDR_RESET;
				default: addr = 8'($urandom_range(0, 255));
			endcase
			settle();
			set_device_address(addr);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				push_random_frame(n);
				sent += n;
			end
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/gfd_pkg.sv
rtl/core/gfd_frame.sv
rtl/core/gfd_out.sv
rtl/core/gauge_reply_frame_decoder.sv
rtl/core/gfd_checker.sv
tb/gauge_reply_frame_decoder_tb.sv
